// File: design/es2d_pkg.sv
package es2d_pkg;

    localparam logic [11:0] EPOCH_YEAR       = 12'd1970;
    localparam logic [16:0] DAY_SECONDS      = 17'd86400;
    localparam logic [16:0] HOUR_SECONDS     = 17'd3600;
    localparam logic [16:0] MINUTE_SECONDS   = 17'd60;
    localparam logic [8:0]  DAYS_COMMON_YEAR = 9'd365;

    // year mod 100 and mod 400 at the epoch
    localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
    localparam logic [8:0]  EPOCH_MOD400 = 9'd370;

    localparam logic [3:0]  MONTH_JAN = 4'd0;
    localparam logic [3:0]  MONTH_FEB = 4'd1;
    localparam logic [3:0]  MONTH_DEC = 4'd11;

    // request to the bit-serial divider
    typedef struct packed {
        logic       start;
        logic [5:0] steps;
    } div_ctl_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            unique case (m)
                4'd1:                   len = leap ? 5'd29 : 5'd28;
                4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
                default:                len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// File: design/es2d_div.sv
module es2d_div
    import es2d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_ctl_t    ctl,
    input  logic [31:0] dividend,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [16:0] remainder
);

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] num_reg, num_next;
    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] div_reg, div_next;

    logic [17:0] shifted;
    logic [17:0] diff;
    logic        fits;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted   = {rem_reg, num_reg[31]};
        diff      = shifted - {1'b0, div_reg};
        fits      = !diff[17];
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (ctl.start)
        begin
            run_next = 1'b1;
            cnt_next = ctl.steps;
            num_next = dividend;
            quo_next = '0;
            rem_next = '0;
            div_next = divisor;
        end
        else if (run_reg)
        begin
            num_next = {num_reg[30:0], 1'b0};
            quo_next = {quo_reg[30:0], fits};
            rem_next = fits ? diff[16:0] : shifted[16:0];
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> rem_reg < div_reg)
        else $error("divider remainder reached divisor");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.start && ctl.steps != 6'd0) |=> run_reg && !done_reg)
        else $error("divider did not start");

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(run_reg))
        else $error("divider done without a run");
`endif

endmodule

// File: design/epoch_seconds_to_utc_date.sv
// Each transaction runs three bit-serial divisions (day, hour, minute), a year walk,
// a month walk and a load of the output register.
// A result still waiting at the output stalls the final step; a new input is taken
// while a result waits.
// Reset: rst_n is asynchronous, active low; clears the sequencer and the output valid.
module epoch_seconds_to_utc_date
    import es2d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // epoch_seconds[31:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // calendar_year[11:0], month_number[15:12], day_of_month[20:16],
    // hour_of_day[25:21], minute_of_hour[31:26], second_of_minute[37:32], zero[39:38]
    output logic [39:0] m_axis_tdata
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DIV_DAY = 3'd1;
    localparam logic [2:0] ST_DIV_HR  = 3'd2;
    localparam logic [2:0] ST_DIV_MIN = 3'd3;
    localparam logic [2:0] ST_YEAR    = 3'd4;
    localparam logic [2:0] ST_MONTH   = 3'd5;
    localparam logic [2:0] ST_FINISH  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic        ovalid_reg, ovalid_next;
    logic [39:0] odata_reg, odata_next;

    logic [15:0] days_reg, days_next;
    logic [11:0] year_reg, year_next;
    logic [6:0]  mod100_reg, mod100_next;
    logic [8:0]  mod400_reg, mod400_next;
    logic [3:0]  month_reg, month_next;
    logic        leap_reg, leap_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;

    div_ctl_t    div_ctl;
    logic [31:0] div_dividend;
    logic [16:0] div_divisor;
    logic        div_done;
    logic [31:0] div_quo;
    logic [16:0] div_rem;

    logic        leap_now;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic        in_accept;
    logic        out_free;

    es2d_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ovalid_reg || m_axis_tready;

    assign leap_now = (mod400_reg == 9'd0) || ((mod100_reg != 7'd0) && (year_reg[1:0] == 2'd0));
    assign ylen     = DAYS_COMMON_YEAR + {8'd0, leap_now};
    assign mlen     = month_len(month_reg, leap_reg);

    always_comb
    begin
        state_next   = state_reg;
        ovalid_next  = ovalid_reg;
        odata_next   = odata_reg;
        days_next    = days_reg;
        year_next    = year_reg;
        mod100_next  = mod100_reg;
        mod400_next  = mod400_reg;
        month_next   = month_reg;
        leap_next    = leap_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        second_next  = second_reg;
        div_ctl      = '{start: 1'b0, steps: 6'd0};
        div_dividend = s_axis_tdata;
        div_divisor  = DAY_SECONDS;

        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    div_ctl    = '{start: 1'b1, steps: 6'd32};
                    state_next = ST_DIV_DAY;
                end
            end
            ST_DIV_DAY:
            begin
                // seconds of day sit in the top 17 bits; 17 steps give the hour
                div_dividend = {div_rem, 15'd0};
                div_divisor  = HOUR_SECONDS;
                if (div_done)
                begin
                    days_next  = div_quo[15:0];
                    div_ctl    = '{start: 1'b1, steps: 6'd17};
                    state_next = ST_DIV_HR;
                end
            end
            ST_DIV_HR:
            begin
                div_dividend = {div_rem[11:0], 20'd0};
                div_divisor  = MINUTE_SECONDS;
                if (div_done)
                begin
                    hour_next  = div_quo[4:0];
                    div_ctl    = '{start: 1'b1, steps: 6'd12};
                    state_next = ST_DIV_MIN;
                end
            end
            ST_DIV_MIN:
            begin
                if (div_done)
                begin
                    minute_next = div_quo[5:0];
                    second_next = div_rem[5:0];
                    year_next   = EPOCH_YEAR;
                    mod100_next = EPOCH_MOD100;
                    mod400_next = EPOCH_MOD400;
                    state_next  = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                if (days_reg < {7'd0, ylen})
                begin
                    leap_next  = leap_now;
                    month_next = MONTH_JAN;
                    state_next = ST_MONTH;
                end
                else
                begin
                    days_next   = days_reg - {7'd0, ylen};
                    year_next   = year_reg + 12'd1;
                    mod100_next = (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
                    mod400_next = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
                end
            end
            ST_MONTH:
            begin
                if (month_reg == MONTH_DEC || days_reg < {11'd0, mlen})
                    state_next = ST_FINISH;
                else
                begin
                    days_next  = days_reg - {11'd0, mlen};
                    month_next = month_reg + 4'd1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    odata_next  = {2'd0, second_reg, minute_reg, hour_reg,
                                   days_reg[4:0] + 5'd1, month_reg + 4'd1, year_reg};
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg  <= odata_next;
        days_reg   <= days_next;
        year_reg   <= year_next;
        mod100_reg <= mod100_next;
        mod400_reg <= mod400_next;
        month_reg  <= month_next;
        leap_reg   <= leap_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_DIV_DAY)
        else $error("accepted transaction did not start the divider");

    a_year_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_YEAR) |-> (year_reg <= 12'd2106 && year_reg >= EPOCH_YEAR))
        else $error("year walk out of range");

    a_leap_counters: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_YEAR && mod400_reg == 9'd0) |-> mod100_reg == 7'd0)
        else $error("leap counters out of step");

    a_day_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (days_reg < 16'd31 && month_reg <= MONTH_DEC))
        else $error("day of month out of range");

    a_month_feb: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && month_reg == MONTH_FEB) |-> days_reg < 16'd29)
        else $error("february day out of range");
`endif

endmodule
